[hdl/mbrot_pkg.sv]
`timescale 1ns / 1ps

package mbrot_pkg;

  localparam int FRAC_BITS = 28;
  localparam int IN_W      = 32;
  localparam int LIM_W     = 16;
  localparam int OUT_W     = 16;
  localparam int XW        = FRAC_BITS + 5;
  localparam int MW        = FRAC_BITS + 1;
  localparam int PW        = 2 * MW;
  localparam int TW        = PW - FRAC_BITS;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd255;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_status_t;

endpackage

[hdl/mbrot_ctrl.sv]
`timescale 1ns / 1ps

module mbrot_ctrl import mbrot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.escaped || status.at_limit) begin
          if (out_free) begin
            cmd.emit   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[hdl/mbrot_datapath.sv]
`timescale 1ns / 1ps

module mbrot_datapath import mbrot_pkg::*; #(
  parameter int CNT_W = 16
) (
  input  logic              clk,
  input  dp_cmd_t           cmd,
  input  logic [IN_W-1:0]   c_real,
  input  logic [IN_W-1:0]   c_imag,
  input  logic [CNT_W-1:0]  limit,
  output dp_status_t        status,
  output logic [OUT_W-1:0]  iter_count,
  output logic              in_set
);

  logic signed [XW-1:0]   x;
  logic signed [XW-1:0]   y;
  logic signed [IN_W-1:0] cr;
  logic signed [IN_W-1:0] ci;
  logic [CNT_W-1:0]       count;
  logic                   big;
  logic                   neg;
  logic [PW-1:0]          xx;
  logic [PW-1:0]          yy;
  logic [PW-1:0]          xy;

  logic [XW-1:0]          ax;
  logic [XW-1:0]          ay;
  logic [MW-1:0]          mx;
  logic [MW-1:0]          my;
  logic [PW:0]            mag_sum;
  logic [XW-1:0]          xx_e;
  logic [XW-1:0]          yy_e;
  logic signed [XW-1:0]   xy_e;
  logic signed [XW-1:0]   xy_s;
  logic signed [XW-1:0]   cr_e;
  logic signed [XW-1:0]   ci_e;
  logic signed [XW-1:0]   x_next;
  logic signed [XW-1:0]   y_next;

  // magnitudes and operand slices; |x| or |y| >= 2 escapes at once
  assign ax = x[XW-1] ? XW'(-x) : XW'(x);
  assign ay = y[XW-1] ? XW'(-y) : XW'(y);
  assign mx = ax[MW-1:0];
  assign my = ay[MW-1:0];

  // escape test on exact squares against 4
  assign mag_sum = {1'b0, xx} + {1'b0, yy};
  assign status.escaped  = big || mag_sum[PW];
  assign status.at_limit = (count >= limit);

  // truncate products toward zero
  assign xx_e = {{(XW-TW){1'b0}}, xx[PW-1:FRAC_BITS]};
  assign yy_e = {{(XW-TW){1'b0}}, yy[PW-1:FRAC_BITS]};
  assign xy_e = {{(XW-TW){1'b0}}, xy[PW-1:FRAC_BITS]};
  assign xy_s = neg ? -xy_e : xy_e;
  assign cr_e = {{(XW-IN_W){cr[IN_W-1]}}, cr};
  assign ci_e = {{(XW-IN_W){ci[IN_W-1]}}, ci};

  assign x_next = $signed(xx_e) - $signed(yy_e) + cr_e;
  assign y_next = (xy_s <<< 1) + ci_e;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= c_real;
      ci    <= c_imag;
      x     <= {{(XW-IN_W){c_real[IN_W-1]}}, c_real};
      y     <= {{(XW-IN_W){c_imag[IN_W-1]}}, c_imag};
      count <= '0;
    end else if (cmd.step) begin
      x     <= x_next;
      y     <= y_next;
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      big <= (|ax[XW-1:MW]) || (|ay[XW-1:MW]);
      neg <= x[XW-1] ^ y[XW-1];
      xx  <= PW'(mx) * PW'(mx);
      yy  <= PW'(my) * PW'(my);
      xy  <= PW'(mx) * PW'(my);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      iter_count <= OUT_W'(count);
      in_set     <= status.at_limit;
    end
  end

endmodule

[hdl/mandelbrot_escape_time.sv]
`timescale 1ns / 1ps
// channel   direction  signals                        transaction
// s_axis    in         s_tvalid s_tready s_tdata      one point c
// m_axis    out        m_tvalid m_tready m_tdata/user one escape result
// cfg       in         cfg_wr_en cfg_wr_data          iteration limit write
//
// one iteration is a multiply state followed by an escape/update state
// a point holds the block until its loop ends; no new point is accepted meanwhile
// rst clears the state machine, the output valid and sets the limit to 255
// a finished result waits in the output register; the next point is accepted
// while it waits; the loop holds at its last step only if full and m_tready low

module mandelbrot_escape_time import mbrot_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,     // c_real, c_imag
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,     // iter_count
  output logic [0:0]       m_tuser,     // in_set
  input  logic             cfg_wr_en,
  input  logic [LIM_W-1:0] cfg_wr_data
);

  localparam int CNT_W = (COUNT_WIDTH < LIM_W) ? COUNT_WIDTH : LIM_W;
  localparam int CAP   = (1 << CNT_W) - 1;

  logic [LIM_W-1:0] iteration_limit;
  logic [LIM_W-1:0] limit_capped;
  logic [CNT_W-1:0] limit;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             in_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      iteration_limit <= cfg_wr_data;
    end
  end

  assign limit_capped = (iteration_limit > LIM_W'(CAP)) ? LIM_W'(CAP) : iteration_limit;
  assign limit        = limit_capped[CNT_W-1:0];

  mbrot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbrot_datapath #(
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .c_real     (s_tdata[31:0]),
    .c_imag     (s_tdata[63:32]),
    .limit      (limit),
    .status     (status),
    .iter_count (m_tdata),
    .in_set     (in_set)
  );

  assign m_tuser = in_set;

endmodule

[hdl/mbrot_checker.sv]
`timescale 1ns / 1ps

module mbrot_checker import mbrot_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [15:0]      m_tdata,
  input logic [0:0]       m_tuser,
  input logic             cfg_wr_en,
  input logic [LIM_W-1:0] cfg_wr_data
);

  localparam int CNT_W = (COUNT_WIDTH < LIM_W) ? COUNT_WIDTH : LIM_W;
  localparam int CAP   = (1 << CNT_W) - 1;

  logic [LIM_W-1:0] lim_seen;
  logic [LIM_W-1:0] lim_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_seen <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      lim_seen <= cfg_wr_data;
    end
  end

  assign lim_eff = (lim_seen > LIM_W'(CAP)) ? LIM_W'(CAP) : lim_seen;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= lim_eff)
    else $error("count above limit");

  a_in_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tdata == lim_eff)))
    else $error("in_set does not match count");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("point accepted while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time mbrot_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata),
  .m_tuser     (m_tuser),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

[tb/mandelbrot_escape_time_test.sv]
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;
  import mbrot_pkg::*;

  localparam int IDLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ONE          = 1 << FRAC_BITS;

  typedef struct packed {
    logic [OUT_W-1:0] iter_count;
    logic             in_set;
  } escape_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;
  logic [0:0]       m_tuser;
  logic             cfg_wr_en = 1'b0;
  logic [LIM_W-1:0] cfg_wr_data = '0;

  escape_t          escapes_due[$];
  logic [LIM_W-1:0] limit_shadow = LIMIT_RESET;
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               calm = 1'b0;

  always #5 clk = ~clk;

  mandelbrot_escape_time #(.COUNT_WIDTH(16)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // exact product, truncated toward zero back to the fixed point scale
  function automatic longint fixed_product(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    r = p[FRAC_BITS +: 64];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit has_escaped(longint x, longint y);
    logic [127:0] ax, ay;
    ax = {64'd0, magnitude(x)};
    ay = {64'd0, magnitude(y)};
    if (ax >= (128'd1 << (FRAC_BITS + 1)) || ay >= (128'd1 << (FRAC_BITS + 1)))
      return 1'b1;
    return ax * ax + ay * ay >= (128'd1 << (2 * FRAC_BITS + 2));
  endfunction

  function automatic escape_t trace_orbit(logic [IN_W-1:0] re, logic [IN_W-1:0] im,
                                          logic [LIM_W-1:0] lim);
    longint      cr, ci, x, y, nx;
    int unsigned count;
    escape_t     r;
    cr = longint'(signed'(re));
    ci = longint'(signed'(im));
    x = cr;
    y = ci;
    count = 0;
    while (count < lim && !has_escaped(x, y)) begin
      nx = fixed_product(x, x) - fixed_product(y, y) + cr;
      y = 2 * fixed_product(x, y) + ci;
      x = nx;
      count++;
    end
    r.iter_count = count[OUT_W-1:0];
    r.in_set = (count >= lim);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pick_coord(bit imag);
    int v;
    if ($urandom_range(0, 9) == 0) begin
      v = $urandom();
    end else if (imag) begin
      v = int'($urandom_range(0, 2 * ONE)) - ONE;
    end else begin
      v = int'($urandom_range(0, 3 * ONE)) - ((ONE / 4) * 9);
    end
    return v;
  endfunction

  task automatic send_point(logic [IN_W-1:0] re, logic [IN_W-1:0] im);
    int      gap;
    escape_t want;
    gap = calm ? 0 : $urandom_range(0, 11);
    want = trace_orbit(re, im, limit_shadow);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {im, re};
    do @(posedge clk); while (!s_tready);
    escapes_due.push_back(want);
  endtask

  task automatic finish_burst();
    s_tvalid <= 1'b0;
    while (escapes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIM_W-1:0] v);
    finish_burst();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_shadow = v;
    @(posedge clk);
  endtask

  // reset limit, no register write yet
  task automatic test_reset_limit();
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hF000_0000, 32'h0000_0000);
    send_point(32'hE000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h1000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h1000_0000);
    send_point(32'h0000_0000, 32'hF000_0000);
    send_point(32'h1FFF_FFFF, 32'h0000_0000);
    send_point(32'h0000_0000, 32'hE000_0001);
    send_point(32'h0428_F5C2, 32'h0000_0000);
    send_point(32'hF400_0000, 32'h0199_999A);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_limit_extremes();
    set_limit(16'd0);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h0000_0000);
    set_limit(16'd1);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hE000_0000, 32'h0000_0000);
    set_limit(16'hFFFF);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hF000_0000, 32'h0000_0000);
    send_point(32'h0428_F5C2, 32'h0000_0000);
  endtask

  task automatic test_random_orbits();
    logic [LIM_W-1:0] lim;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        2:       lim = 16'd255;
        4:       lim = $urandom_range(41, 120);
        default: lim = $urandom_range(2, 40);
      endcase
      set_limit(lim);
      calm = (phase == 3);
      for (int n = 0; n < 100; n++) send_point(pick_coord(1'b0), pick_coord(1'b1));
    end
    calm = 1'b0;
  endtask

  initial begin
    wait (!rst);
    forever begin
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : check_results
    escape_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (escapes_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: count=%0d in_set=%0b", m_tdata, m_tuser[0]);
        mismatches++;
      end else begin
        want = escapes_due.pop_front();
        if (m_tdata !== want.iter_count || m_tuser[0] !== want.in_set) begin
          if (mismatches < 10)
            $display("mismatch: expected count=%0d in_set=%0b, got count=%0d in_set=%0b",
                     want.iter_count, want.in_set, m_tdata, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mandelbrot_escape_time_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limit();
    test_limit_extremes();
    test_random_orbits();
    finish_burst();
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_test: clean");
    end else begin
      $display("mandelbrot_escape_time_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mbrot_pkg.sv
hdl/mbrot_ctrl.sv
hdl/mbrot_datapath.sv
hdl/mandelbrot_escape_time.sv
hdl/mbrot_checker.sv
tb/mandelbrot_escape_time_test.sv
